### rtl/core/pmnt_pkg.sv
// ============================================================================
// pmnt_pkg : shared types and constants for the prefix match number table
// Operation codes, entry layout and sizing defaults.
// ============================================================================
package pmnt_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int MAX_DIGITS_DEF  = 16;
    localparam int HOURS_PER_DAY   = 24;

    // operation codes
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_AGED   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // entry as held in the table: digits, length, tag, hour
    localparam int ENTRY_W = 64 + 5 + 16 + 32;

    typedef struct packed {
        logic [63:0] digits;
        logic [4:0]  len;
        logic [15:0] tag;
        logic [31:0] hour;
    } entry_t;

    // mask of the first len digits, first digit in the top nibble
    function automatic logic [63:0] top_mask(input logic [4:0] len);
        logic [63:0] m;
        m = '0;
        for (int k = 0; k < 16; k++) begin
            if (k < int'(len)) begin
                m[63 - 4*k -: 4] = 4'hF;
            end
        end
        return m;
    endfunction

endpackage

### rtl/core/pmnt_ram.sv
// ============================================================================
// pmnt_ram : generic single-port RAM with registered read
// One write or one read per cycle, read data in the next cycle.
// ============================================================================
module pmnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/core/pmnt_ctrl.sv
// ============================================================================
// pmnt_ctrl : table walk sequencer
// Walks the stored entries at most once per operation, matching, ageing and
// compacting through a single RAM port.
// ============================================================================
module pmnt_ctrl #(
    parameter int MAX_ENTRIES = pmnt_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_DIGITS  = pmnt_pkg::MAX_DIGITS_DEF,
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // command
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic [1:0]            cmd_kind,
    input  logic [63:0]           cmd_digits,
    input  logic [4:0]            cmd_len,
    input  logic [15:0]           cmd_tag,
    input  logic [31:0]           cmd_now,
    input  logic [15:0]           cmd_days,
    // RAM port
    output logic                  ram_we,
    output logic [AW-1:0]         ram_addr,
    output pmnt_pkg::entry_t      ram_wdata,
    input  pmnt_pkg::entry_t      ram_rdata,
    // result
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic                  res_found,
    output logic [15:0]           res_tag,
    output logic [1:0]            res_status,
    output logic                  res_removed,
    output logic [6:0]            res_count
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    held_reg, held_next;
    logic [CW-1:0]    rd_reg, rd_next;     // read index
    logic [CW-1:0]    wr_reg, wr_next;     // compaction write index
    logic [1:0]       kind_reg;
    logic [63:0]      digits_reg;
    logic [4:0]       len_reg;
    logic [15:0]      tag_reg;
    logic [31:0]      now_reg;
    logic [31:0]      limit_reg;
    pmnt_pkg::entry_t hold_reg, hold_next;
    logic             found_reg, found_next;
    logic [15:0]      mtag_reg, mtag_next;
    logic [1:0]       status_reg, status_next;
    logic             removed_reg, removed_next;
    logic             valid_reg, valid_next;

    logic [4:0]  len_cl;
    logic        match;
    logic        aged;
    logic [31:0] age;

    assign len_cl = (int'(cmd_len) > MAX_DIGITS) ? 5'(MAX_DIGITS) : cmd_len;

    // entry tests on the word just read
    assign match = (ram_rdata.len <= len_reg) &&
                   (((ram_rdata.digits ^ digits_reg) &
                     pmnt_pkg::top_mask(ram_rdata.len)) == 64'd0);
    assign age   = now_reg - ram_rdata.hour;
    assign aged  = age > limit_reg;

    assign cmd_ready = (state_reg == S_IDLE) && !valid_reg;

    always_comb begin
        state_next   = state_reg;
        held_next    = held_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        hold_next    = hold_reg;
        found_next   = found_reg;
        mtag_next    = mtag_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        valid_next   = valid_reg;
        ram_we       = 1'b0;
        ram_addr     = rd_reg[AW-1:0];
        ram_wdata    = hold_reg;
        if (valid_reg && res_ready) begin
            valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    rd_next      = '0;
                    wr_next      = '0;
                    found_next   = 1'b0;
                    mtag_next    = '0;
                    status_next  = pmnt_pkg::ST_OK;
                    removed_next = 1'b0;
                    state_next   = S_RD;
                end
            end
            S_RD: begin
                // issue a read or finish the walk
                if (rd_reg >= held_reg) begin
                    if (kind_reg == pmnt_pkg::OP_ADD && !found_reg) begin
                        if (held_reg >= CW'(MAX_ENTRIES)) begin
                            status_next = pmnt_pkg::ST_FULL;
                            state_next  = S_OUT;
                        end else begin
                            hold_next.digits = digits_reg;
                            hold_next.len    = len_reg;
                            hold_next.tag    = tag_reg;
                            hold_next.hour   = now_reg;
                            wr_next          = held_reg;
                            held_next        = held_reg + 1'b1;
                            state_next       = S_WR;
                        end
                    end else begin
                        if (kind_reg == pmnt_pkg::OP_REMOVE ||
                            kind_reg == pmnt_pkg::OP_AGED) begin
                            held_next = wr_reg;
                        end
                        state_next = S_OUT;
                    end
                end else begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                rd_next = rd_reg + 1'b1;
                if (kind_reg == pmnt_pkg::OP_LOOKUP || kind_reg == pmnt_pkg::OP_ADD) begin
                    if (match) begin
                        found_next  = 1'b1;
                        mtag_next   = ram_rdata.tag;
                        status_next = (kind_reg == pmnt_pkg::OP_ADD) ?
                                      pmnt_pkg::ST_DUP : pmnt_pkg::ST_OK;
                        state_next  = S_OUT;
                    end else begin
                        state_next = S_RD;
                    end
                end else begin
                    if ((kind_reg == pmnt_pkg::OP_REMOVE) ? match : aged) begin
                        removed_next = 1'b1;
                        state_next   = S_RD;
                    end else if (wr_reg != rd_reg) begin
                        hold_next  = ram_rdata;
                        state_next = S_WR;
                    end else begin
                        wr_next    = wr_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_WR: begin
                ram_we    = 1'b1;
                ram_addr  = wr_reg[AW-1:0];
                wr_next   = wr_reg + 1'b1;
                state_next = (kind_reg == pmnt_pkg::OP_ADD) ? S_OUT : S_RD;
            end
            S_OUT: begin
                valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            held_reg  <= held_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg      <= rd_next;
        wr_reg      <= wr_next;
        hold_reg    <= hold_next;
        found_reg   <= found_next;
        mtag_reg    <= mtag_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        if (cmd_valid && cmd_ready) begin
            kind_reg   <= cmd_kind;
            len_reg    <= len_cl;
            digits_reg <= cmd_digits & pmnt_pkg::top_mask(len_cl);
            tag_reg    <= cmd_tag;
            now_reg    <= cmd_now;
            limit_reg  <= 32'(cmd_days) * 32'(pmnt_pkg::HOURS_PER_DAY);
        end
    end

    assign res_valid   = valid_reg;
    assign res_found   = found_reg;
    assign res_tag     = mtag_reg;
    assign res_status  = status_reg;
    assign res_removed = removed_reg;
    assign res_count   = 7'(held_reg);
endmodule

### rtl/core/prefix_match_number_table_core.sv
// ============================================================================
// prefix_match_number_table_core : ordered prefix table with table walk
// Lookup, add, remove and erase-aged over entries held in one RAM.
// ============================================================================
//  channel | dir | tdata fields (low bit up)                          | tuser
//  s_      | in  | number_digits, number_length, name_tag, now_hours,   | kind
//          |     | max_days                                            |
//  m_      | out | found, matched_name_tag, status, removed_any,       | -
//          |     | entry_count                                         |
// An operation passes each entry it visits through a read state and an evaluate
// state, plus a write state per entry moved, all through the single RAM port.
// One operation at a time; the next transfer is taken once the result
// has left. Reset empties the table at once (no clearing pass).
// m_tvalid holds its transfer until m_tready.
module prefix_match_number_table_core #(
    parameter int MAX_ENTRIES = pmnt_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_DIGITS  = pmnt_pkg::MAX_DIGITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // digits[63:0] len[68:64] tag[84:69] now[116:85] days[132:117]
    input  logic [1:0]   s_tuser,  // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata   // found[0] tag[16:1] status[18:17] removed[19] count[26:20]
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    pmnt_pkg::entry_t ram_wdata, ram_rdata;
    logic             found, removed;
    logic [15:0]      mtag;
    logic [1:0]       status;
    logic [6:0]       count;

    pmnt_ctrl #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_DIGITS(MAX_DIGITS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(s_tvalid), .cmd_ready(s_tready), .cmd_kind(s_tuser),
        .cmd_digits(s_tdata[63:0]), .cmd_len(s_tdata[68:64]),
        .cmd_tag(s_tdata[84:69]), .cmd_now(s_tdata[116:85]),
        .cmd_days(s_tdata[132:117]),
        .ram_we(ram_we), .ram_addr(ram_addr), .ram_wdata(ram_wdata),
        .ram_rdata(ram_rdata),
        .res_valid(m_tvalid), .res_ready(m_tready), .res_found(found),
        .res_tag(mtag), .res_status(status), .res_removed(removed),
        .res_count(count)
    );

    pmnt_ram #(.WIDTH(pmnt_pkg::ENTRY_W), .DEPTH(1 << AW)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr),
        .wdata(ram_wdata), .rdata(ram_rdata)
    );

    assign m_tdata = {5'd0, count, removed, status, mtag, found};
endmodule

### rtl/core/pmnt_checker.sv
// ============================================================================
// pmnt_checker : port-level checks for the prefix match number table
// Watches the stream ports and is bound to the top level.
// ============================================================================
module pmnt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata
);
    // result stays offered until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    // no input taken while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken with result pending");

    // status never a reserved code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18:17] != 2'd3)
        else $error("bad status");

    // an accepted transfer is not followed by ready next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held after accept");
endmodule

bind prefix_match_number_table_core pmnt_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### tb/pmnt_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// pmnt_monitor : result prediction and comparison for the prefix table
// Watches both channels, keeps its own copy of the table, predicts each
// result on input transfer and compares each output transfer in order.
// ============================================================================
module pmnt_monitor (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic [6:0]  count;
        logic        removed;
        logic [1:0]  status;
        logic [15:0] tag;
        logic        found;
    } outcome_t;

    pmnt_pkg::entry_t table_q[$];
    outcome_t         outcome_q[$];

    function automatic logic [63:0] lead_mask(input int n);
        logic [63:0] m;
        m = '0;
        for (int k = 0; k < n; k++) m[63 - 4*k -: 4] = 4'hF;
        return m;
    endfunction

    function automatic bit prefix_hit(input pmnt_pkg::entry_t e, input logic [63:0] d,
                                      input int n);
        if (int'(e.len) > n) return 1'b0;
        return ((e.digits ^ d) & lead_mask(int'(e.len))) == 64'd0;
    endfunction

    // apply one operation to the table copy and give the result
    function automatic outcome_t apply_op(input logic [1:0] op, input logic [135:0] d);
        outcome_t         r;
        pmnt_pkg::entry_t e;
        pmnt_pkg::entry_t kept[$];
        int               n;
        int               hit;
        logic [63:0]      dig;
        logic [31:0]      now;
        logic [31:0]      age;
        logic [63:0]      lim;
        r = '0;
        n = int'(d[68:64]);
        if (n > 16) n = 16;
        dig = d[63:0] & lead_mask(n);
        now = d[116:85];
        lim = 64'(d[132:117]) * 64'(pmnt_pkg::HOURS_PER_DAY);
        if (op == pmnt_pkg::OP_LOOKUP || op == pmnt_pkg::OP_ADD) begin
            hit = -1;
            foreach (table_q[i])
                if (hit < 0 && prefix_hit(table_q[i], dig, n)) hit = i;
            if (hit >= 0) begin
                r.found = 1'b1;
                r.tag = table_q[hit].tag;
                if (op == pmnt_pkg::OP_ADD) r.status = pmnt_pkg::ST_DUP;
            end else if (op == pmnt_pkg::OP_ADD) begin
                if (table_q.size() >= pmnt_pkg::MAX_ENTRIES_DEF) begin
                    r.status = pmnt_pkg::ST_FULL;
                end else begin
                    e.digits = dig; e.len = 5'(n); e.tag = d[84:69]; e.hour = now;
                    table_q = {table_q, e};
                end
            end
        end else begin
            foreach (table_q[i]) begin
                age = now - table_q[i].hour;
                if (op == pmnt_pkg::OP_REMOVE ? prefix_hit(table_q[i], dig, n)
                                              : (64'(age) > lim))
                    r.removed = 1'b1;
                else
                    kept = {kept, table_q[i]};
            end
            table_q = kept;
        end
        r.count = 7'(table_q.size());
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // predict on input transfer, compare on output transfer
    always @(posedge aclk) begin
        outcome_t w;
        outcome_t g;
        if (!aresetn) begin
            table_q = {};
            outcome_q = {};
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready) outcome_q = {outcome_q, apply_op(s_tuser, s_tdata)};
            if (m_tvalid && m_tready) begin
                g = m_tdata[26:0];
                if (outcome_q.size() == 0) begin
                    report("unexpected transfer", m_tdata, 32'd0);
                end else begin
                    w = outcome_q.pop_front();
                    if (g.found !== w.found)
                        report("found", 32'(g.found), 32'(w.found));
                    if (g.tag !== w.tag)
                        report("name tag", 32'(g.tag), 32'(w.tag));
                    if (g.status !== w.status)
                        report("status", 32'(g.status), 32'(w.status));
                    if (g.removed !== w.removed)
                        report("removed", 32'(g.removed), 32'(w.removed));
                    if (g.count !== w.count)
                        report("count", 32'(g.count), 32'(w.count));
                end
            end
        end
        pending = outcome_q.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top : stimulus and verdict for the prefix match number table
// Directed corner operations, then random traffic over a small digit
// alphabet so prefixes collide often, with bursty input and output stalls.
// ============================================================================
module tb_top;

    localparam int WATCHDOG = 20000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    int           fail_count;
    int           pending;
    bit           hold_off;
    int           idle_cycles;

    prefix_match_number_table_core uut (.*);

    pmnt_monitor chk (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // one transfer; valid stays up into the next one unless a gap is taken
    task automatic send(input logic [1:0] op, input logic [63:0] dig, input logic [4:0] n,
                        input logic [15:0] tag, input logic [31:0] now,
                        input logic [15:0] days);
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b0, days, now, tag, n, dig};
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid after the last transfer of a run
    task automatic idle_input();
        s_tvalid <= 1'b0;
    endtask

    // random digits from a narrow alphabet, occasional full-range nibbles
    function automatic logic [63:0] rand_digits();
        logic [63:0] d;
        for (int k = 0; k < 16; k++)
            d[4*k +: 4] = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        return d;
    endfunction

    function automatic logic [4:0] rand_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13) return 5'($urandom_range(1, 4));
        if (r < 18) return 5'($urandom_range(0, 16));
        return 5'($urandom_range(17, 31));
    endfunction

    // receiver stall pattern with one long hold-off
    initial begin
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off) m_tready <= 0;
            else m_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    // watchdog over cycles with no transfer
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] now;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tuser  = pmnt_pkg::OP_LOOKUP;
        hold_off = 0;
        aresetn  = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed corners
        send(pmnt_pkg::OP_LOOKUP, '1, 5'd16, 16'd0, 32'd0, 16'd0);
        send(pmnt_pkg::OP_REMOVE, '1, 5'd16, 16'd0, 32'd0, 16'd0);
        send(pmnt_pkg::OP_AGED, 64'd0, 5'd0, 16'd0, 32'd0, 16'd0);
        send(pmnt_pkg::OP_ADD, 64'h1234_5678_9ABC_DEFF, 5'd3, 16'hFFFF, 32'd100, 16'd0);
        send(pmnt_pkg::OP_ADD, 64'h1230_0000_0000_0000, 5'd5, 16'h1, 32'd100, 16'd0);
        send(pmnt_pkg::OP_LOOKUP, 64'h1234_0000_0000_0000, 5'd2, 16'd0, 32'd0, 16'd0);
        send(pmnt_pkg::OP_LOOKUP, 64'h1239_0000_0000_0000, 5'd4, 16'd0, 32'd0, 16'd0);
        send(pmnt_pkg::OP_ADD, 64'hDEF0_0000_0000_0000, 5'd31, 16'h0, 32'hFFFF_FFFF, 16'd0);
        send(pmnt_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 5'd20, 16'hABCD, 32'd0, 16'd0);
        send(pmnt_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 16'd0, 32'd0, 16'd0);
        send(pmnt_pkg::OP_ADD, 64'h0, 5'd0, 16'h5555, 32'd200, 16'd0);
        send(pmnt_pkg::OP_LOOKUP, 64'h7, 5'd1, 16'd0, 32'd0, 16'd0);
        send(pmnt_pkg::OP_AGED, 64'd0, 5'd0, 16'd0, 32'd50, 16'hFFFF);
        send(pmnt_pkg::OP_AGED, 64'd0, 5'd0, 16'd0, 32'd124, 16'd1);
        send(pmnt_pkg::OP_REMOVE, 64'h0, 5'd0, 16'd0, 32'd0, 16'd0);
        // fill the table to full, then try once more
        for (int k = 0; k < 65; k++)
            send(pmnt_pkg::OP_ADD, {8'(k), 56'h0}, 5'd2, 16'(k), 32'd1000, 16'd0);
        send(pmnt_pkg::OP_ADD, 64'h0, 5'd0, 16'd0, 32'd0, 16'd0);
        send(pmnt_pkg::OP_AGED, 64'd0, 5'd0, 16'd0, 32'd1000, 16'd0);
        send(pmnt_pkg::OP_AGED, 64'd0, 5'd0, 16'd0, 32'd999, 16'd0);

        // sender pauses until all results are back
        idle_input();
        wait (pending == 0);

        // long receiver hold-off while items are offered
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
        join_none

        now = 32'd5000;
        for (int k = 0; k < 320; k++) begin
            logic [1:0] op;
            int r;
            r = $urandom_range(0, 99);
            op = (r < 45) ? pmnt_pkg::OP_ADD : (r < 75) ? pmnt_pkg::OP_LOOKUP :
                 (r < 93) ? pmnt_pkg::OP_REMOVE : pmnt_pkg::OP_AGED;
            now = now + $urandom_range(0, 30);
            if ($urandom_range(0, 30) == 0) now = $urandom;
            send(op, rand_digits(), rand_len(), 16'($urandom), now,
                 ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)));
        end

        idle_input();
        wait (pending == 0);
        repeat (300) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
